>>> sv/crc16_mirrored_byte_update_assert.svh
// Assertion macros for the mirrored-byte CRC-16 update block.
// Included by the top level; it depends on nothing else.
`ifndef CRC16_MIRRORED_BYTE_UPDATE_ASSERT_SVH
`define CRC16_MIRRORED_BYTE_UPDATE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRCMB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crcmb: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CRCMB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crcmb: next-cycle check failed");

`endif

>>> sv/crcmb_pkg.sv
// Shared types, register indexes and CRC functions for the mirrored-byte CRC-16 block.
// Depends on nothing; every module of the block imports it.
package crcmb_pkg;

   localparam int CrcWidth  = 16;
   localparam int ByteWidth = 8;

   localparam logic [15:0] PolynomialReset   = 16'h002d;
   localparam logic [15:0] InitialValueReset = 16'h0000;

   localparam logic CSR_POLYNOMIAL    = 1'b0;
   localparam logic CSR_INITIAL_VALUE = 1'b1;

   typedef struct packed {
      logic [ByteWidth-1:0] data_byte;
      logic                 restart;
      logic                 block_end;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } stage_type;

   typedef struct packed {
      logic [CrcWidth-1:0] crc_value;
      logic                block_done;
   } result_type;

   function automatic logic [ByteWidth-1:0] reverse_byte(input logic [ByteWidth-1:0] b);
      logic [ByteWidth-1:0] r;
      for (int i = 0; i < ByteWidth; i++) begin
         r[i] = b[ByteWidth-1-i];
      end
      return r;
   endfunction

   function automatic logic [CrcWidth-1:0] table_term(input logic [ByteWidth-1:0] d,
                                                      input logic [CrcWidth-1:0] poly);
      logic [CrcWidth:0] v;
      v = {1'b0, d, {ByteWidth{1'b0}}};
      for (int i = 0; i < ByteWidth; i++) begin
         v = {v[CrcWidth-1:0], 1'b0};
         if (v[CrcWidth]) begin
            v = {1'b0, v[CrcWidth-1:0] ^ poly};
         end
      end
      return v[CrcWidth-1:0];
   endfunction

endpackage

>>> sv/crcmb_in_stage.sv
// Input register stage: holds one accepted transaction until the update stage takes it.
// Depends on crcmb_pkg.
module crcmb_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  crcmb_pkg::item_type req_item,
   output logic                req_stall,
   input  logic                advance,
   output crcmb_pkg::stage_type stage
);
   import crcmb_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     accept;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

>>> sv/crcmb_update.sv
// Combinational CRC update for one byte: restart select, bit reversal and table term.
// Depends on crcmb_pkg.
module crcmb_update (
   input  crcmb_pkg::item_type         item,
   input  logic [crcmb_pkg::CrcWidth-1:0] running_crc,
   input  logic [crcmb_pkg::CrcWidth-1:0] polynomial,
   input  logic [crcmb_pkg::CrcWidth-1:0] initial_value,
   output crcmb_pkg::result_type       result
);
   import crcmb_pkg::*;

   logic [CrcWidth-1:0] start_crc;

   assign start_crc = item.restart ? initial_value : running_crc;

   assign result.crc_value  = {start_crc[ByteWidth-1:0], {ByteWidth{1'b0}}}
                            ^ table_term(start_crc[CrcWidth-1:ByteWidth], polynomial)
                            ^ {{(CrcWidth-ByteWidth){1'b0}}, reverse_byte(item.data_byte)};
   assign result.block_done = item.block_end;

endmodule

>>> sv/crc16_mirrored_byte_update.sv
// Top level of the mirrored-byte CRC-16 block: registers, result stage and checks.
// Depends on crcmb_pkg, crcmb_in_stage, crcmb_update and the assertion header.
`include "crc16_mirrored_byte_update_assert.svh"
// Usage:
// The req channel carries one message byte per transaction together with a
// restart flag, which loads the initial value first, and a block end flag.
// The rsp channel returns one transaction per request: the running CRC after
// that byte and the block end flag echoed as block_done.
// A transaction accepted into the input register passes on to the result register,
// which drives rsp; while rsp is stalled it waits in the input register.
// One byte is accepted every cycle while rsp is not stalled; the limit is the
// combinational update from the running CRC register, through an eight-step
// polynomial reduction, back into that register.
// When rsp_stall is high the result holds, the input register fills, and then
// req_stall rises; nothing is lost or repeated.
// The csr port writes the polynomial (index 0) and the initial value (index 1)
// and must only be used while no transaction is in flight.
// Synchronous reset empties both stages, sets the polynomial to 0x002D and
// clears the initial value and the running CRC.
module crc16_mirrored_byte_update (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_restart,
   input  logic        req_block_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_crc_value,
   output logic        rsp_block_done,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);
   import crcmb_pkg::*;

   item_type            req_item;
   stage_type           stage;
   result_type          result;
   logic                advance;
   logic [CrcWidth-1:0] polynomial_ff;
   logic [CrcWidth-1:0] polynomial_in;
   logic [CrcWidth-1:0] initial_value_ff;
   logic [CrcWidth-1:0] initial_value_in;
   logic [CrcWidth-1:0] running_crc_ff;
   logic [CrcWidth-1:0] running_crc_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   result_type          result_ff;

   assign req_item.data_byte = req_data_byte;
   assign req_item.restart   = req_restart;
   assign req_item.block_end = req_block_end;

   crcmb_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .req_stall (req_stall),
      .advance   (advance),
      .stage     (stage)
   );

   crcmb_update u_update (
      .item          (stage.item),
      .running_crc   (running_crc_ff),
      .polynomial    (polynomial_ff),
      .initial_value (initial_value_ff),
      .result        (result)
   );

   assign advance      = stage.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign running_crc_in = advance ? result.crc_value : running_crc_ff;

   always_comb begin
      polynomial_in    = polynomial_ff;
      initial_value_in = initial_value_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_POLYNOMIAL:    polynomial_in    = csr_write_data;
            CSR_INITIAL_VALUE: initial_value_in = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         polynomial_ff    <= PolynomialReset;
         initial_value_ff <= InitialValueReset;
         running_crc_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         polynomial_ff    <= polynomial_in;
         initial_value_ff <= initial_value_in;
         running_crc_ff   <= running_crc_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_crc_value  = result_ff.crc_value;
   assign rsp_block_done = result_ff.block_done;

   `CRCMB_ASSERT_NEXT(a_crc_matches_result, clock, reset, advance,
      rsp_valid && (rsp_crc_value == running_crc_ff))
   `CRCMB_ASSERT_SAME(a_stall_needs_item, clock, reset, req_stall, stage.valid)
   `CRCMB_ASSERT_NEXT(a_result_drains, clock, reset,
      rsp_valid && !rsp_stall && !advance, !rsp_valid)

endmodule
